FILE: sv/plts_pkg.sv
// Package for the token scanner: scanner states, token kind codes,
// character constants, the result record and small classification helpers.
// No dependencies.
package plts_pkg;

  // Limits of the length and line counters
  localparam logic [7:0]  TOKEN_LENGTH_MAX = 8'd255;
  localparam logic [15:0] LINE_COUNT_MAX   = 16'd65535;

  // Result records that one request can produce
  localparam int unsigned RES_DEPTH = 3;

  // Scanner states, one-hot
  typedef enum logic [13:0] {
    S_START   = 14'b00000000000001,
    S_WORD    = 14'b00000000000010,
    S_INT     = 14'b00000000000100,
    S_INTDOT  = 14'b00000000001000,
    S_REAL    = 14'b00000000010000,
    S_QUOTE   = 14'b00000000100000,
    S_COLON   = 14'b00000001000000,
    S_LESS    = 14'b00000010000000,
    S_GREATER = 14'b00000100000000,
    S_EQUAL   = 14'b00001000000000,
    S_OPENPAR = 14'b00010000000000,
    S_BRACE   = 14'b00100000000000,
    S_PARCMT  = 14'b01000000000000,
    S_PARSTAR = 14'b10000000000000
  } scan_state_t;

  // Token kinds
  localparam logic [4:0] K_END       = 5'd0;
  localparam logic [4:0] K_WORD      = 5'd1;
  localparam logic [4:0] K_INT       = 5'd2;
  localparam logic [4:0] K_REAL      = 5'd3;
  localparam logic [4:0] K_CHAR      = 5'd4;
  localparam logic [4:0] K_STRING    = 5'd5;
  localparam logic [4:0] K_COMMENT   = 5'd6;
  localparam logic [4:0] K_PLUS      = 5'd7;
  localparam logic [4:0] K_MINUS     = 5'd8;
  localparam logic [4:0] K_STAR      = 5'd9;
  localparam logic [4:0] K_SLASH     = 5'd10;
  localparam logic [4:0] K_LPAREN    = 5'd11;
  localparam logic [4:0] K_RPAREN    = 5'd12;
  localparam logic [4:0] K_LBRACKET  = 5'd13;
  localparam logic [4:0] K_RBRACKET  = 5'd14;
  localparam logic [4:0] K_COMMA     = 5'd15;
  localparam logic [4:0] K_SEMI      = 5'd16;
  localparam logic [4:0] K_PERIOD    = 5'd17;
  localparam logic [4:0] K_COLON     = 5'd18;
  localparam logic [4:0] K_ASSIGN    = 5'd19;
  localparam logic [4:0] K_LT        = 5'd20;
  localparam logic [4:0] K_LE        = 5'd21;
  localparam logic [4:0] K_NE        = 5'd22;
  localparam logic [4:0] K_GT        = 5'd23;
  localparam logic [4:0] K_GE        = 5'd24;
  localparam logic [4:0] K_EQEQ      = 5'd25;
  localparam logic [4:0] K_UNKNOWN   = 5'd26;

  // Characters with a role in the grammar
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_QUOTE    = 8'h27;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_PERIOD   = 8'h2E;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_EQ       = 8'h3D;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;

  // One result record
  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  length;
    logic        sat;
    logic [15:0] line;
    logic        last;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Kind of a character that forms a token on its own
  function automatic logic [4:0] single_op(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h2B:     k = K_PLUS;
      8'h2D:     k = K_MINUS;
      8'h2A:     k = K_STAR;
      8'h2F:     k = K_SLASH;
      8'h29:     k = K_RPAREN;
      8'h5B:     k = K_LBRACKET;
      8'h5D:     k = K_RBRACKET;
      8'h2C:     k = K_COMMA;
      8'h3B:     k = K_SEMI;
      8'h2E:     k = K_PERIOD;
      default:   k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  // Saturating length step: returns {overflow, length}
  function automatic logic [8:0] grow(input logic [7:0] len, input logic ovf);
    logic [8:0] r;
    if (len < TOKEN_LENGTH_MAX) begin
      r = {ovf, len + 8'd1};
    end else begin
      r = {1'b1, len};
    end
    return r;
  endfunction

  // Count a line feed, saturating
  function automatic logic [15:0] count_line(input logic [15:0] ln, input logic [7:0] c);
    logic [15:0] r;
    r = ln;
    if ((c == CH_LF) && (ln < LINE_COUNT_MAX)) begin
      r = ln + 16'd1;
    end
    return r;
  endfunction

  function automatic res_t mk_res(input logic [4:0] k, input logic [7:0] len,
                                  input logic sat, input logic [15:0] ln);
    res_t r;
    r.kind   = k;
    r.length = len;
    r.sat    = sat;
    r.line   = ln;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

FILE: sv/pascal_like_token_scanner.sv
// Token scanner top level: scanner state, token records and output queue.
// Depends on plts_pkg.
//
// Usage:
//   Source channel (src_valid/src_stall) carries one request per cycle: a
//   source byte, or an end-of-source mark (kind = 1 or a zero byte).
//   Token channel (tok_valid/tok_stall) returns token records: kind, length,
//   saturation flag, line number and last (set on the final record of a
//   request). A request may give zero to three records.
//   Records of a request appear on the token channel in the cycle after the
//   request is taken. Throughput: one request per cycle while each request
//   gives at most one record and the token channel does not stall; a request
//   that gives more than one record occupies the three-entry output queue,
//   and the source side stalls until the queue drains to its last entry being taken.
//   The scanner step is one pass of logic from the state registers and the
//   request to the output queue.
//   Reset (rst, synchronous) empties the queue and sets the scanner to its
//   start state, length zero, line 1. An end-of-source request does the same
//   to the scanner state after flushing pending tokens and an end token.
//   A stalled token record holds until taken; the scanner state is not
//   affected by token-side stalls other than through src_stall.
module pascal_like_token_scanner
  import plts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic        kind,
  input  logic [7:0]  char_byte,
  output logic        tok_valid,
  input  logic        tok_stall,
  output logic [4:0]  token_kind,
  output logic [7:0]  token_length,
  output logic        length_saturated,
  output logic [15:0] line_number,
  output logic        last
);

  // Scanner state
  scan_state_t scan_state, scan_state_next;
  logic [7:0]  token_length_count, token_length_count_next;
  logic        length_overflow, length_overflow_next;
  logic [15:0] line_counter, line_counter_next;

  // Output queue
  res_t        q [RES_DEPTH];
  logic [1:0]  cnt;

  // Step results
  res_t        r [RES_DEPTH];
  logic [1:0]  n_res;

  logic        src_take;
  logic        tok_take;
  logic        end_req;

  assign tok_valid = (cnt != 2'd0);
  assign tok_take  = tok_valid && !tok_stall;
  // Take a request only if the queue is empty after this cycle's pop
  assign src_stall = !((cnt == 2'd0) || ((cnt == 2'd1) && !tok_stall));
  assign src_take  = src_valid && !src_stall;
  assign end_req   = kind || (char_byte == CH_NUL);

  assign token_kind       = q[0].kind;
  assign token_length     = q[0].length;
  assign length_saturated = q[0].sat;
  assign line_number      = q[0].line;
  assign last             = q[0].last;

  // Scan one request
  always_comb begin
    scan_state_t st;
    logic [7:0]  len;
    logic        ovf;
    logic [15:0] ln;
    logic [1:0]  n;
    logic        rescan;
    logic [7:0]  c;

    st     = scan_state;
    len    = token_length_count;
    ovf    = length_overflow;
    ln     = line_counter;
    n      = 2'd0;
    rescan = 1'b0;
    c      = char_byte;
    for (int i = 0; i < RES_DEPTH; i++) begin
      r[i] = mk_res(K_END, 8'd0, 1'b0, 16'd0);
    end

    if (end_req) begin
      // Flush the pending token, then the end token
      case (st)
        S_WORD: begin
          r[n] = mk_res(K_WORD, len, ovf, ln); n = n + 2'd1;
        end
        S_INT: begin
          r[n] = mk_res(K_INT, len, ovf, ln); n = n + 2'd1;
        end
        S_INTDOT: begin
          r[n] = mk_res(K_INT, len, ovf, ln); n = n + 2'd1;
          r[n] = mk_res(K_PERIOD, 8'd1, 1'b0, ln); n = n + 2'd1;
        end
        S_REAL: begin
          r[n] = mk_res(K_REAL, len, ovf, ln); n = n + 2'd1;
        end
        S_QUOTE, S_BRACE, S_PARCMT, S_PARSTAR: begin
          r[n] = mk_res(K_UNKNOWN, len, ovf, ln); n = n + 2'd1;
        end
        S_COLON: begin
          r[n] = mk_res(K_COLON, 8'd1, 1'b0, ln); n = n + 2'd1;
        end
        S_LESS: begin
          r[n] = mk_res(K_LT, 8'd1, 1'b0, ln); n = n + 2'd1;
        end
        S_GREATER: begin
          r[n] = mk_res(K_GT, 8'd1, 1'b0, ln); n = n + 2'd1;
        end
        S_EQUAL: begin
          r[n] = mk_res(K_UNKNOWN, 8'd1, 1'b0, ln); n = n + 2'd1;
        end
        S_OPENPAR: begin
          r[n] = mk_res(K_LPAREN, 8'd1, 1'b0, ln); n = n + 2'd1;
        end
        default: begin
        end
      endcase
      r[n] = mk_res(K_END, 8'd0, 1'b0, ln); n = n + 2'd1;
      // Return to the reset state for the next source
      st  = S_START;
      len = 8'd0;
      ovf = 1'b0;
      ln  = 16'd1;
    end else begin
      // Continue the token in progress
      case (st)
        S_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            {ovf, len} = grow(len, ovf);
          end else begin
            r[n] = mk_res(K_WORD, len, ovf, ln); n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_INT: begin
          if (is_digit(c)) begin
            {ovf, len} = grow(len, ovf);
          end else if (c == CH_PERIOD) begin
            st = S_INTDOT;
          end else begin
            r[n] = mk_res(K_INT, len, ovf, ln); n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_INTDOT: begin
          // The period after the digits counts once a digit follows
          if (is_digit(c)) begin
            {ovf, len} = grow(len, ovf);
            {ovf, len} = grow(len, ovf);
            st = S_REAL;
          end else begin
            r[n] = mk_res(K_INT, len, ovf, ln); n = n + 2'd1;
            r[n] = mk_res(K_PERIOD, 8'd1, 1'b0, ln); n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_REAL: begin
          if (is_digit(c)) begin
            {ovf, len} = grow(len, ovf);
          end else begin
            r[n] = mk_res(K_REAL, len, ovf, ln); n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_QUOTE: begin
          if (c == CH_LF) begin
            // A line break inside a quote spoils the literal
            ln = count_line(ln, c);
            r[n] = mk_res(K_UNKNOWN, len, ovf, ln); n = n + 2'd1;
            st = S_START;
          end else begin
            {ovf, len} = grow(len, ovf);
            if (c == CH_QUOTE) begin
              r[n] = mk_res((!ovf && (len == 8'd3)) ? K_CHAR : K_STRING, len, ovf, ln);
              n = n + 2'd1;
              st = S_START;
            end
          end
        end
        S_COLON: begin
          if (c == CH_EQ) begin
            r[n] = mk_res(K_ASSIGN, 8'd2, 1'b0, ln); n = n + 2'd1;
            st = S_START;
          end else begin
            r[n] = mk_res(K_COLON, 8'd1, 1'b0, ln); n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_LESS: begin
          if (c == CH_EQ) begin
            r[n] = mk_res(K_LE, 8'd2, 1'b0, ln); n = n + 2'd1;
            st = S_START;
          end else if (c == CH_GT) begin
            r[n] = mk_res(K_NE, 8'd2, 1'b0, ln); n = n + 2'd1;
            st = S_START;
          end else begin
            r[n] = mk_res(K_LT, 8'd1, 1'b0, ln); n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_GREATER: begin
          if (c == CH_EQ) begin
            r[n] = mk_res(K_GE, 8'd2, 1'b0, ln); n = n + 2'd1;
            st = S_START;
          end else begin
            r[n] = mk_res(K_GT, 8'd1, 1'b0, ln); n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_EQUAL: begin
          if (c == CH_EQ) begin
            r[n] = mk_res(K_EQEQ, 8'd2, 1'b0, ln); n = n + 2'd1;
            st = S_START;
          end else begin
            r[n] = mk_res(K_UNKNOWN, 8'd1, 1'b0, ln); n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_OPENPAR: begin
          if (c == CH_STAR) begin
            len = 8'd2;
            ovf = 1'b0;
            st  = S_PARCMT;
          end else begin
            r[n] = mk_res(K_LPAREN, 8'd1, 1'b0, ln); n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_BRACE: begin
          {ovf, len} = grow(len, ovf);
          ln = count_line(ln, c);
          if (c == CH_RBRACE) begin
            r[n] = mk_res(K_COMMENT, len, ovf, ln); n = n + 2'd1;
            st = S_START;
          end
        end
        S_PARCMT: begin
          {ovf, len} = grow(len, ovf);
          ln = count_line(ln, c);
          if (c == CH_STAR) begin
            st = S_PARSTAR;
          end
        end
        S_PARSTAR: begin
          {ovf, len} = grow(len, ovf);
          ln = count_line(ln, c);
          if (c == CH_RPAREN) begin
            r[n] = mk_res(K_COMMENT, len, ovf, ln); n = n + 2'd1;
            st = S_START;
          end else if (c != CH_STAR) begin
            st = S_PARCMT;
          end
        end
        default: begin
          rescan = 1'b1;
        end
      endcase

      // Scan the byte from the start state
      if (rescan) begin
        st = S_START;
        if (is_space(c)) begin
          ln = count_line(ln, c);
        end else begin
          len = 8'd1;
          ovf = 1'b0;
          if (is_alpha(c)) begin
            st = S_WORD;
          end else if (is_digit(c)) begin
            st = S_INT;
          end else if (c == CH_QUOTE) begin
            st = S_QUOTE;
          end else if (c == CH_COLON) begin
            st = S_COLON;
          end else if (c == CH_LT) begin
            st = S_LESS;
          end else if (c == CH_GT) begin
            st = S_GREATER;
          end else if (c == CH_EQ) begin
            st = S_EQUAL;
          end else if (c == CH_LPAREN) begin
            st = S_OPENPAR;
          end else if (c == CH_LBRACE) begin
            st = S_BRACE;
          end else begin
            r[n] = mk_res(single_op(c), 8'd1, 1'b0, ln); n = n + 2'd1;
          end
        end
      end
    end

    // Mark the final record
    if (n != 2'd0) begin
      r[n - 2'd1].last = 1'b1;
    end

    scan_state_next         = st;
    token_length_count_next = len;
    length_overflow_next    = ovf;
    line_counter_next       = ln;
    n_res                   = n;
  end

  // Advance the scanner state on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state         <= S_START;
      token_length_count <= 8'd0;
      length_overflow    <= 1'b0;
      line_counter       <= 16'd1;
    end else if (src_take) begin
      scan_state         <= scan_state_next;
      token_length_count <= token_length_count_next;
      length_overflow    <= length_overflow_next;
      line_counter       <= line_counter_next;
    end
  end

  // Load new records or shift the queue down on a pop
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (src_take) begin
      cnt <= n_res;
    end else if (tok_take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      for (int i = 0; i < RES_DEPTH; i++) begin
        q[i] <= r[i];
      end
    end else if (tok_take) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

  // An end-of-source request leaves the scanner in its reset state
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (src_take && end_req) |=>
      (scan_state == S_START && line_counter == 16'd1 && token_length_count == 8'd0))
    else $error("scanner state not reset after end of source");

  // The end token has zero length and closes the request
  a_end_token: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && token_kind == K_END) |-> (token_length == 8'd0 && last))
    else $error("end token malformed");

  // The newest queued record always carries the last flag
  a_last_tail: assert property (@(posedge clk) disable iff (rst)
    (cnt != 2'd0) |-> ((cnt == 2'd1 && q[0].last) || (cnt == 2'd2 && q[1].last)
                       || (cnt == 2'd3 && q[2].last)))
    else $error("queue tail missing last flag");

  // The head record carries no last flag while more records follow it
  a_last_head: assert property (@(posedge clk) disable iff (rst)
    (cnt > 2'd1) |-> !q[0].last)
    else $error("last flag before queue tail");

endmodule
